>>> hdl/mpc2_pkg.sv
// mpc2_pkg: shared types and constants for the matched point chi2 core
// no dependencies
`default_nettype none
package mpc2_pkg;

    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam int SUM_W = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] y_error;
    } in_word_t;

    typedef struct packed {
        logic [47:0] chi2_per_dof;
        logic [16:0] match_count;
        logic        points_dropped;
        logic        sum_saturated;
    } out_word_t;

    // start request to the divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [33:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/mpc2_div.sv
// mpc2_div: radix-2 restoring divider, one quotient bit per cycle
// depends on mpc2_pkg
`default_nettype none
module mpc2_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpc2_pkg::div_req_t req,
    output mpc2_pkg::div_rsp_t     rsp
);
    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [33:0] dvs_reg, dvs_next;
    logic        done_reg, done_next;
    logic [34:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[32:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

>>> hdl/mpc2_store.sv
// mpc2_store: point store, one write port and one registered read port
// depends on nothing
`default_nettype none
module mpc2_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [63:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [63:0]        rd_data
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hdl/matched_point_chi2_per_dof_core.sv
// matched_point_chi2_per_dof_core: top level, load/compute sequencer
// depends on mpc2_pkg, mpc2_store, mpc2_div
//
// Loads (action 0 or 1) write one point word per cycle while the core is
// idle into the first or second point store and produce no result. A compute
// word (action 2) walks all first-set points (outer) against all second-set
// points (inner), reading one pair from the two single-port-read memories per
// step. Each pair passes through S_READ and S_EVAL; a pair that matches in x
// with errors in use and a nonzero error sum also waits in S_WDIV, because
// the weighted term goes through a shared bit-serial divider. The final
// sum/(count-1) uses the same divider when more than one pair matched, else
// the result is zero. Action 3 is ignored. The result word sits in an output
// register; no new word is taken until it has been delivered. Compute clears
// both fill counts and flags.
`default_nettype none
module matched_point_chi2_per_dof_core #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mpc2_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mpc2_pkg::out_word_t      out_data
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = AW + 1;
    localparam int SUM_W_L = mpc2_pkg::SUM_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_WDIV  = 3'd3;
    localparam logic [2:0] S_FDIV  = 3'd4;
    localparam logic [2:0] S_FWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    st_reg, st_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic          err_reg, err_next, drop_reg, drop_next;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next;
    logic [SUM_W_L-1:0] sum_reg, sum_next;
    logic [16:0]   mcnt_reg, mcnt_next;
    logic          sat_reg, sat_next;
    logic          more_reg, more_next;    // another pair follows this one
    mpc2_pkg::out_word_t res_reg, res_next;

    logic          wr_a, wr_b;
    logic [63:0]   wr_word;
    logic [63:0]   rd_a, rd_b;

    mpc2_pkg::div_req_t dreq;
    mpc2_pkg::div_rsp_t drsp;

    logic          take;
    logic signed [16:0] d;
    logic [33:0]   num, den;
    logic [31:0]   e1sq, e2sq;
    logic [48:0]   add;
    logic [47:0]   term;
    logic          term_sat;

    assign take    = in_valid && in_ready;
    assign in_ready = (st_reg == S_IDLE);
    assign wr_word = {in_data.y_error, in_data.y_value, in_data.x_value};
    assign wr_a = take && in_data.action == mpc2_pkg::ACT_LOAD_A
                  && cnt_a_reg < CW'(MAX_POINTS);
    assign wr_b = take && in_data.action == mpc2_pkg::ACT_LOAD_B
                  && cnt_b_reg < CW'(MAX_POINTS);

    mpc2_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store_a (
        .clk(clk), .wr_en(wr_a), .wr_addr(cnt_a_reg[AW-1:0]),
        .wr_data(wr_word), .rd_addr(i_reg), .rd_data(rd_a));
    mpc2_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store_b (
        .clk(clk), .wr_en(wr_b), .wr_addr(cnt_b_reg[AW-1:0]),
        .wr_data(wr_word), .rd_addr(j_reg), .rd_data(rd_b));

    mpc2_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // pair arithmetic on the registered read words, squares at full width
    always_comb
    begin
        d    = 17'(signed'(rd_b[47:32])) - 17'(signed'(rd_a[47:32]));
        num  = unsigned'(34'(d) * 34'(d));
        e1sq = unsigned'(32'(signed'(rd_a[63:48])) * 32'(signed'(rd_a[63:48])));
        e2sq = unsigned'(32'(signed'(rd_b[63:48])) * 32'(signed'(rd_b[63:48])));
        den  = 34'(e1sq) + 34'(e2sq);
    end

    // term feeding the accumulator: divider quotient or raw square
    always_comb
    begin
        if (st_reg == S_WDIV)
        begin
            term_sat = |drsp.quotient[63:48];
            term     = term_sat ? mpc2_pkg::SUM_MAX : drsp.quotient[47:0];
        end
        else
        begin
            term_sat = 1'b0;
            term     = 48'(num);
        end
        add = 49'(sum_reg) + 49'(term);
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        err_next  = err_reg;
        drop_next = drop_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        sum_next  = sum_reg;
        mcnt_next = mcnt_reg;
        sat_next  = sat_reg;
        more_next = more_reg;
        res_next  = res_reg;
        dreq      = '0;
        case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (in_data.action)
                        mpc2_pkg::ACT_LOAD_A:
                        begin
                            if (wr_a)
                            begin
                                cnt_a_next = cnt_a_reg + CW'(1);
                                if (in_data.y_error != '0)
                                    err_next = 1'b1;
                            end
                            else
                                drop_next = 1'b1;
                        end
                        mpc2_pkg::ACT_LOAD_B:
                        begin
                            if (wr_b)
                            begin
                                cnt_b_next = cnt_b_reg + CW'(1);
                                if (in_data.y_error != '0)
                                    err_next = 1'b1;
                            end
                            else
                                drop_next = 1'b1;
                        end
                        mpc2_pkg::ACT_COMPUTE:
                        begin
                            i_next    = '0;
                            j_next    = '0;
                            sum_next  = '0;
                            mcnt_next = '0;
                            sat_next  = 1'b0;
                            if (cnt_a_reg == '0 || cnt_b_reg == '0)
                                st_next = S_FDIV;
                            else
                                st_next = S_READ;
                        end
                        default:
                            st_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                // memory read in flight for (i, j); step indices now
                more_next = 1'b1;
                if (CW'(j_reg) + CW'(1) < cnt_b_reg)
                    j_next = j_reg + AW'(1);
                else
                begin
                    j_next = '0;
                    if (CW'(i_reg) + CW'(1) < cnt_a_reg)
                        i_next = i_reg + AW'(1);
                    else
                        more_next = 1'b0;
                end
                st_next = S_EVAL;
            end
            S_EVAL:
            begin
                st_next = more_reg ? S_READ : S_FDIV;
                if (rd_a[31:0] == rd_b[31:0])
                begin
                    if (err_reg)
                    begin
                        if (den != '0)
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = {14'd0, num, 16'd0};
                            dreq.divisor  = den;
                            st_next       = S_WDIV;
                        end
                    end
                    else
                    begin
                        mcnt_next = mcnt_reg + 17'd1;
                        sum_next  = add[48] ? mpc2_pkg::SUM_MAX : add[47:0];
                        if (add[48])
                            sat_next = 1'b1;
                    end
                end
            end
            S_WDIV:
            begin
                if (drsp.done)
                begin
                    mcnt_next = mcnt_reg + 17'd1;
                    sum_next  = add[48] ? mpc2_pkg::SUM_MAX : add[47:0];
                    if (add[48] || term_sat)
                        sat_next = 1'b1;
                    st_next = more_reg ? S_READ : S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (mcnt_reg > 17'd1)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {16'd0, sum_reg};
                    dreq.divisor  = 34'(mcnt_reg - 17'd1);
                    st_next       = S_FWAIT;
                end
                else
                begin
                    res_next.chi2_per_dof = '0;
                    res_next.match_count  = mcnt_reg;
                    res_next.points_dropped = drop_reg;
                    res_next.sum_saturated  = sat_reg;
                    st_next = S_OUT;
                end
            end
            S_FWAIT:
            begin
                if (drsp.done)
                begin
                    res_next.chi2_per_dof   = drsp.quotient[47:0];
                    res_next.match_count    = mcnt_reg;
                    res_next.points_dropped = drop_reg;
                    res_next.sum_saturated  = sat_reg;
                    st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cnt_a_next = '0;
                cnt_b_next = '0;
                err_next   = 1'b0;
                drop_next  = 1'b0;
                if (out_ready)
                    st_next = S_IDLE;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            err_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            more_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            err_reg   <= err_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        mcnt_reg <= mcnt_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign out_valid = (st_reg == S_OUT);
    assign out_data  = res_reg;
endmodule
`default_nettype wire

>>> hdl/mpc2_checker.sv
// mpc2_checker: port-level checks on the matched point chi2 core
// depends on mpc2_pkg; bound to matched_point_chi2_per_dof_core
`default_nettype none
module mpc2_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire mpc2_pkg::in_word_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire mpc2_pkg::out_word_t out_data
);
    // result word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // no new input word while a result waits
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // a load never yields a result next cycle
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action != mpc2_pkg::ACT_COMPUTE
        |=> !out_valid)
        else $error("result after load");

    // fewer than two matches gives zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.match_count < 17'd2 |-> out_data.chi2_per_dof == '0)
        else $error("nonzero result with too few matches");
endmodule

bind matched_point_chi2_per_dof_core mpc2_checker u_mpc2_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data));
`default_nettype wire
